// ----- hw/rtl/kpc_pkg.sv -----
// Package for the keyed Polybius codec: constants, ASCII codes, status codes,
// result and key status types, and small cell index helpers.
// No dependencies.
package kpc_pkg;

   localparam int unsigned KEY_BITS     = 60;
   localparam int unsigned CODE_W       = 5;
   localparam int unsigned KEY_SLOTS    = 32;
   localparam int unsigned SQUARE_DEPTH = 25;
   localparam int unsigned LETTER_DEPTH = 26;

   localparam logic [4:0] SQUARE_SIDE  = 5'd5;
   localparam logic [4:0] SQUARE_CELLS = 5'd25;
   localparam logic [4:0] KEY_MAX      = 5'd25;
   localparam logic [4:0] LETTERS      = 5'd26;
   localparam logic [4:0] CODE_I       = 5'd8;
   localparam logic [4:0] CODE_J       = 5'd9;

   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_ONE  = 8'h31;
   localparam logic [7:0] CHAR_FIVE = 8'h35;
   localparam logic [7:0] CHAR_NINE = 8'h39;
   localparam logic [7:0] CHAR_UA   = 8'h41;
   localparam logic [7:0] CHAR_UZ   = 8'h5A;
   localparam logic [7:0] CHAR_LA   = 8'h61;
   localparam logic [7:0] CHAR_LZ   = 8'h7A;

   typedef enum logic [1:0] {
      REG_KEY_LENGTH = 2'd0,
      REG_KEY_FIRST  = 2'd1,
      REG_KEY_SECOND = 2'd2,
      REG_KEY_FINAL  = 2'd3
   } reg_index_type;

   typedef enum logic [1:0] {
      STAT_OK         = 2'd0,
      STAT_BAD_KEY    = 2'd1,
      STAT_BAD_PLAIN  = 2'd2,
      STAT_BAD_CIPHER = 2'd3
   } status_type;

   typedef struct packed {
      logic [7:0] out_char;
      status_type status;
      logic       last;
   } result_type;

   typedef struct packed {
      logic building;
      logic key_valid;
   } key_status_type;

   function automatic result_type make_result(input logic [7:0] ch, input status_type st,
                                              input logic last);
      result_type r;
      r.out_char = ch;
      r.status   = st;
      r.last     = last;
      return r;
   endfunction

   function automatic logic [2:0] cell_row(input logic [4:0] p);
      logic [2:0] r;
      if (p >= 5'd20) begin
         r = 3'd4;
      end else if (p >= 5'd15) begin
         r = 3'd3;
      end else if (p >= 5'd10) begin
         r = 3'd2;
      end else if (p >= SQUARE_SIDE) begin
         r = 3'd1;
      end else begin
         r = 3'd0;
      end
      return r;
   endfunction

   function automatic logic [2:0] cell_col(input logic [4:0] p);
      logic [2:0] r;
      logic [4:0] base;
      r    = cell_row(p);
      base = {r, 2'b00} + {2'b00, r};
      return 3'(p - base);
   endfunction

endpackage

// ----- hw/rtl/kpc_keysched.sv -----
// Key registers and square builder: holds the configuration, walks the key and
// the alphabet one letter per cycle to fill the square and position tables.
// Depends on kpc_pkg.
module kpc_keysched (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [1:0]                  csr_index,
   input  logic [kpc_pkg::KEY_BITS-1:0] csr_data,
   output kpc_pkg::key_status_type     key_status,
   input  logic [4:0]                  pos_addr,
   output logic [4:0]                  pos_data,
   input  logic [4:0]                  cell_addr,
   output logic [4:0]                  cell_letter
);

   typedef enum logic [1:0] {
      BUILD_IDLE,
      BUILD_KEYS,
      BUILD_ALPHA
   } build_state_type;

   build_state_type state_ff, state_in;
   logic [4:0]                  key_len_ff;
   logic [kpc_pkg::KEY_BITS-1:0] key_first_ff;
   logic [kpc_pkg::KEY_BITS-1:0] key_second_ff;
   logic [4:0]                  key_final_ff;
   logic [4:0]  n_ff, n_in;
   logic [4:0]  c_ff, c_in;
   logic [31:0] used_ff, used_in;
   logic        ok_ff, ok_in;
   logic        valid_ff, valid_in;
   logic        csr_fire;
   logic        len_ok;
   logic        wr_en;
   logic [4:0]  wr_code;
   logic [4:0]  key_code;
   logic [4:0]  key_code_arr [kpc_pkg::KEY_SLOTS];
   logic [4:0]  square_ff [kpc_pkg::SQUARE_DEPTH];
   logic [4:0]  pos_ff [kpc_pkg::LETTER_DEPTH];

   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid & csr_ready;
   assign len_ok    = (key_len_ff != 5'd0) && (key_len_ff <= kpc_pkg::KEY_MAX);

   always_comb begin
      for (int k = 0; k < kpc_pkg::KEY_SLOTS; k++) begin
         if (k < 12) begin
            key_code_arr[k] = key_first_ff[5*k +: 5];
         end else if (k < 24) begin
            key_code_arr[k] = key_second_ff[5*(k-12) +: 5];
         end else if (k == 24) begin
            key_code_arr[k] = key_final_ff;
         end else begin
            key_code_arr[k] = 5'd0;
         end
      end
   end

   assign key_code = key_code_arr[n_ff];

   always_comb begin
      state_in = state_ff;
      n_in     = n_ff;
      c_in     = c_ff;
      used_in  = used_ff;
      ok_in    = ok_ff;
      valid_in = valid_ff;
      wr_en    = 1'b0;
      wr_code  = key_code;
      unique case (state_ff)
         BUILD_IDLE: begin
         end
         BUILD_KEYS: begin
            priority if (!len_ok) begin
               ok_in    = 1'b0;
               used_in  = '0;
               n_in     = 5'd0;
               c_in     = 5'd0;
               state_in = BUILD_ALPHA;
            end else if (n_ff == key_len_ff) begin
               ok_in    = 1'b1;
               c_in     = 5'd0;
               state_in = BUILD_ALPHA;
            end else if (key_code >= kpc_pkg::LETTERS || key_code == kpc_pkg::CODE_J ||
                         used_ff[key_code]) begin
               ok_in    = 1'b0;
               used_in  = '0;
               n_in     = 5'd0;
               c_in     = 5'd0;
               state_in = BUILD_ALPHA;
            end else begin
               wr_en             = 1'b1;
               used_in[key_code] = 1'b1;
               n_in              = n_ff + 5'd1;
            end
         end
         BUILD_ALPHA: begin
            if (c_ff == kpc_pkg::LETTERS) begin
               valid_in = ok_ff;
               state_in = BUILD_IDLE;
            end else begin
               if (c_ff != kpc_pkg::CODE_J && !used_ff[c_ff] &&
                   n_ff != kpc_pkg::SQUARE_CELLS) begin
                  wr_en   = 1'b1;
                  wr_code = c_ff;
                  n_in    = n_ff + 5'd1;
               end
               c_in = c_ff + 5'd1;
            end
         end
         default: begin
            state_in = BUILD_IDLE;
         end
      endcase
      if (csr_fire) begin
         state_in = BUILD_KEYS;
         n_in     = 5'd0;
         used_in  = '0;
         valid_in = 1'b0;
         wr_en    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BUILD_KEYS;
         n_ff          <= 5'd0;
         c_ff          <= 5'd0;
         used_ff       <= '0;
         ok_ff         <= 1'b0;
         valid_ff      <= 1'b0;
         key_len_ff    <= 5'd0;
         key_first_ff  <= '0;
         key_second_ff <= '0;
         key_final_ff  <= 5'd0;
      end else begin
         state_ff <= state_in;
         n_ff     <= n_in;
         c_ff     <= c_in;
         used_ff  <= used_in;
         ok_ff    <= ok_in;
         valid_ff <= valid_in;
         if (csr_fire) begin
            unique case (csr_index)
               kpc_pkg::REG_KEY_LENGTH: key_len_ff    <= csr_data[4:0];
               kpc_pkg::REG_KEY_FIRST:  key_first_ff  <= csr_data;
               kpc_pkg::REG_KEY_SECOND: key_second_ff <= csr_data;
               kpc_pkg::REG_KEY_FINAL:  key_final_ff  <= csr_data[4:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         square_ff[n_ff] <= wr_code;
         pos_ff[wr_code] <= n_ff;
      end
   end

   assign pos_data    = pos_ff[pos_addr];
   assign cell_letter = square_ff[cell_addr];

   assign key_status.building  = (state_ff != BUILD_IDLE);
   assign key_status.key_valid = valid_ff;

endmodule

// ----- hw/rtl/kpc_codec.sv -----
// Byte datapath: input register, per-byte encrypt/decrypt decision with the
// pending row digit, and a two-entry result register toward the output.
// Depends on kpc_pkg; table lookups come from kpc_keysched.
module kpc_codec (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [7:0]              req_tdata,
   input  logic                    req_tuser,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [7:0]              rsp_tdata,
   output logic [1:0]              rsp_tuser,
   output logic                    rsp_tlast,
   input  kpc_pkg::key_status_type key_status,
   output logic [4:0]              pos_addr,
   input  logic [4:0]              pos_data,
   output logic [4:0]              cell_addr,
   input  logic [4:0]              cell_letter
);

   logic                 in_valid_ff;
   logic [7:0]           in_char_ff;
   logic                 in_dec_ff;
   logic                 pend_valid_ff, pend_valid_in;
   logic [2:0]           pend_digit_ff, pend_digit_in;
   logic [1:0]           cnt_ff, cnt_in;
   kpc_pkg::result_type  slot0_ff, slot1_ff;
   kpc_pkg::result_type  res0, res1;
   logic                 is_digit, is_upper, is_lower, is_letter, digit_ok;
   logic [7:0]           letter_off;
   logic [4:0]           letter_code;
   logic [2:0]           row0, col0;
   logic                 advance, out_free, rsp_fire;

   assign is_digit  = (in_char_ff >= kpc_pkg::CHAR_ZERO) && (in_char_ff <= kpc_pkg::CHAR_NINE);
   assign is_upper  = (in_char_ff >= kpc_pkg::CHAR_UA) && (in_char_ff <= kpc_pkg::CHAR_UZ);
   assign is_lower  = (in_char_ff >= kpc_pkg::CHAR_LA) && (in_char_ff <= kpc_pkg::CHAR_LZ);
   assign is_letter = is_upper | is_lower;
   assign digit_ok  = (in_char_ff >= kpc_pkg::CHAR_ONE) && (in_char_ff <= kpc_pkg::CHAR_FIVE);

   // J folds onto I
   always_comb begin
      letter_off  = is_upper ? in_char_ff - kpc_pkg::CHAR_UA : in_char_ff - kpc_pkg::CHAR_LA;
      letter_code = is_letter ? letter_off[4:0] : 5'd0;
      if (letter_code == kpc_pkg::CODE_J) begin
         letter_code = kpc_pkg::CODE_I;
      end
   end

   assign pos_addr = letter_code;

   assign row0 = pend_digit_ff - 3'd1;
   assign col0 = in_char_ff[2:0] - 3'd1;
   assign cell_addr = (pend_valid_ff && digit_ok) ?
                      {row0, 2'b00} + {2'b00, row0} + {2'b00, col0} : 5'd0;

   always_comb begin
      cnt_in        = 2'd1;
      res0          = kpc_pkg::make_result(8'd0, kpc_pkg::STAT_OK, 1'b1);
      res1          = kpc_pkg::make_result(8'd0, kpc_pkg::STAT_OK, 1'b1);
      pend_valid_in = pend_valid_ff;
      pend_digit_in = pend_digit_ff;
      if (!in_dec_ff) begin
         priority if (is_digit) begin
            res0.status = kpc_pkg::STAT_BAD_PLAIN;
         end else if (!key_status.key_valid) begin
            res0.status = kpc_pkg::STAT_BAD_KEY;
         end else if (!is_letter) begin
            res0.out_char = in_char_ff;
         end else begin
            cnt_in = 2'd2;
            res0   = kpc_pkg::make_result(kpc_pkg::CHAR_ONE + 8'(kpc_pkg::cell_row(pos_data)),
                                          kpc_pkg::STAT_OK, 1'b0);
            res1   = kpc_pkg::make_result(kpc_pkg::CHAR_ONE + 8'(kpc_pkg::cell_col(pos_data)),
                                          kpc_pkg::STAT_OK, 1'b1);
         end
      end else begin
         pend_valid_in = 1'b0;
         pend_digit_in = 3'd0;
         priority if (is_letter) begin
            res0.status = kpc_pkg::STAT_BAD_CIPHER;
         end else if (!key_status.key_valid) begin
            res0.status = kpc_pkg::STAT_BAD_KEY;
         end else if (is_digit && !digit_ok) begin
            res0.status = kpc_pkg::STAT_BAD_CIPHER;
         end else if (is_digit && !pend_valid_ff) begin
            cnt_in        = 2'd0;
            pend_valid_in = 1'b1;
            pend_digit_in = in_char_ff[2:0];
         end else if (is_digit) begin
            res0.out_char = kpc_pkg::CHAR_UA + 8'(cell_letter);
         end else if (pend_valid_ff) begin
            res0.status = kpc_pkg::STAT_BAD_CIPHER;
         end else begin
            res0.out_char = in_char_ff;
         end
      end
   end

   assign rsp_fire   = rsp_tvalid & rsp_tready;
   assign out_free   = (cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && rsp_tready);
   assign advance    = in_valid_ff & out_free;
   assign req_tready = !key_status.building && (!in_valid_ff || advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         pend_valid_ff <= 1'b0;
         pend_digit_ff <= 3'd0;
         cnt_ff        <= 2'd0;
      end else begin
         if (req_tvalid && req_tready) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (key_status.building) begin
            pend_valid_ff <= 1'b0;
            pend_digit_ff <= 3'd0;
         end else if (advance) begin
            pend_valid_ff <= pend_valid_in;
            pend_digit_ff <= pend_digit_in;
         end
         if (advance) begin
            cnt_ff <= cnt_in;
         end else if (rsp_fire) begin
            cnt_ff <= cnt_ff - 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_char_ff <= req_tdata;
         in_dec_ff  <= req_tuser;
      end
      if (advance) begin
         slot0_ff <= res0;
         slot1_ff <= res1;
      end else if (rsp_fire) begin
         slot0_ff <= slot1_ff;
      end
   end

   assign rsp_tvalid = (cnt_ff != 2'd0);
   assign rsp_tdata  = slot0_ff.out_char;
   assign rsp_tuser  = slot0_ff.status;
   assign rsp_tlast  = slot0_ff.last;

endmodule

// ----- hw/rtl/keyed_polybius_codec_core.sv -----
// Keyed 5x5 Polybius square codec, one byte request at a time on a stream bus.
// Channels: req_* carries a byte and its direction, rsp_* returns result bytes,
// csr_* writes the four key registers (length, letters 0..11, 12..23, 24).
// A request passes the input register and then the result register pair.
// Throughput is one request per cycle for bytes that give one result, while
// rsp_tready is high and no square build runs; after an encrypted letter the
// next request waits in the input register until the second digit leaves the
// single output register pair shared by the two digits. A decrypt digit that
// opens a pair gives no result; the letter comes with the second digit.
// Reset and every csr write start a square build that walks the key and then
// the alphabet one letter per cycle; req_tready stays low meanwhile and any
// pending row digit is dropped. csr writes are always taken.
// When rsp_tready is low the result holds and the input register takes one
// more request before req_tready drops.
// Depends on kpc_pkg, kpc_keysched and kpc_codec.
module keyed_polybius_codec_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_char
   input  logic        req_tuser,   // [0] req_type: 0 encrypt, 1 decrypt
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_char
   output logic [1:0]  rsp_tuser,   // [1:0] status
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [59:0] csr_data
);

   kpc_pkg::key_status_type key_status;
   logic [4:0] pos_addr;
   logic [4:0] pos_data;
   logic [4:0] cell_addr;
   logic [4:0] cell_letter;

   kpc_keysched u_keysched (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .key_status  (key_status),
      .pos_addr    (pos_addr),
      .pos_data    (pos_data),
      .cell_addr   (cell_addr),
      .cell_letter (cell_letter)
   );

   kpc_codec u_codec (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .key_status  (key_status),
      .pos_addr    (pos_addr),
      .pos_data    (pos_data),
      .cell_addr   (cell_addr),
      .cell_letter (cell_letter)
   );

endmodule

// ----- verif/keyed_polybius_codec_core_tb.sv -----
// Testbench for keyed_polybius_codec_core: drives byte requests and key writes,
// predicts every result from its own model of the keyed square, checks each one.
// Depends on kpc_pkg and the codec RTL.
module keyed_polybius_codec_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;   // [7:0] in_char
   logic        req_tuser  = 1'b0;    // [0] req_type: 0 encrypt, 1 decrypt
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;            // [7:0] out_char
   logic [1:0]  rsp_tuser;            // [1:0] status
   logic        rsp_tlast;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index  = 2'd0;
   logic [59:0] csr_data   = '0;

   // model of the block
   logic [4:0]  key_len;
   logic [59:0] key_lo;
   logic [59:0] key_hi;
   logic [4:0]  key_last;
   logic [4:0]  square_cells [25];
   logic [4:0]  letter_cell [26];
   logic        key_ok;
   logic [3:0]  pend_row;
   logic        pend_valid;

   kpc_pkg::result_type queued_outputs [$];
   int          mismatch_count  = 0;
   int          hold_off_cycles = 0;
   bit          send_gaps       = 1'b1;
   bit          rsp_gaps        = 1'b1;

   keyed_polybius_codec_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   function automatic logic [4:0] key_code(input int i);
      if (i < 12) begin
         return key_lo[5*i +: 5];
      end else if (i < 24) begin
         return key_hi[5*(i-12) +: 5];
      end
      return key_last;
   endfunction

   function automatic void rebuild_square();
      logic [31:0] used;
      logic        ok;
      logic [4:0]  code;
      int          n;
      used = '0;
      n    = 0;
      ok   = (key_len >= 5'd1 && key_len <= 5'd25);
      for (int i = 0; i < 25; i++) begin
         if (ok && i < key_len) begin
            code = key_code(i);
            if (code >= 5'd26 || code == kpc_pkg::CODE_J || used[code]) begin
               ok = 1'b0;
            end else begin
               used[code] = 1'b1;
            end
         end
      end
      if (!ok) begin
         used = '0;
      end
      if (ok) begin
         for (int i = 0; i < 25; i++) begin
            if (i < key_len) begin
               square_cells[n] = key_code(i);
               n++;
            end
         end
      end
      for (int c = 0; c < 26; c++) begin
         if (n < 25 && c != kpc_pkg::CODE_J && !used[c]) begin
            square_cells[n] = 5'(c);
            n++;
         end
      end
      for (int c = 0; c < 26; c++) begin
         letter_cell[c] = '0;
      end
      for (int i = 0; i < 25; i++) begin
         letter_cell[square_cells[i]] = 5'(i);
      end
      letter_cell[kpc_pkg::CODE_J] = letter_cell[kpc_pkg::CODE_I];
      key_ok     = ok;
      pend_valid = 1'b0;
      pend_row   = '0;
   endfunction

   function automatic void note_output(input logic [7:0] ch, input kpc_pkg::status_type st,
                                       input logic last);
      kpc_pkg::result_type r;
      r.out_char = ch;
      r.status   = st;
      r.last     = last;
      queued_outputs.push_back(r);
   endfunction

   function automatic void predict_request(input logic dec, input logic [7:0] ch);
      logic       is_digit;
      logic       is_upper;
      logic       is_lower;
      logic [4:0] sq_idx;
      logic [3:0] dval;
      is_digit = (ch >= kpc_pkg::CHAR_ZERO && ch <= kpc_pkg::CHAR_NINE);
      is_upper = (ch >= kpc_pkg::CHAR_UA && ch <= kpc_pkg::CHAR_UZ);
      is_lower = (ch >= kpc_pkg::CHAR_LA && ch <= kpc_pkg::CHAR_LZ);
      if (!dec) begin
         if (is_digit) begin
            note_output(8'h00, kpc_pkg::STAT_BAD_PLAIN, 1'b1);
         end else if (!key_ok) begin
            note_output(8'h00, kpc_pkg::STAT_BAD_KEY, 1'b1);
         end else if (!is_upper && !is_lower) begin
            note_output(ch, kpc_pkg::STAT_OK, 1'b1);
         end else begin
            sq_idx = letter_cell[is_upper ? 5'(ch - kpc_pkg::CHAR_UA) :
                                            5'(ch - kpc_pkg::CHAR_LA)];
            note_output(kpc_pkg::CHAR_ONE + 8'(sq_idx / 5), kpc_pkg::STAT_OK, 1'b0);
            note_output(kpc_pkg::CHAR_ONE + 8'(sq_idx % 5), kpc_pkg::STAT_OK, 1'b1);
         end
      end else if (is_upper || is_lower || !key_ok) begin
         pend_valid = 1'b0;
         pend_row   = '0;
         note_output(8'h00, key_ok ? kpc_pkg::STAT_BAD_CIPHER :
                     ((is_upper || is_lower) ? kpc_pkg::STAT_BAD_CIPHER :
                                               kpc_pkg::STAT_BAD_KEY), 1'b1);
      end else if (is_digit) begin
         dval = 4'(ch - kpc_pkg::CHAR_ZERO);
         if (dval < 4'd1 || dval > 4'd5) begin
            pend_valid = 1'b0;
            pend_row   = '0;
            note_output(8'h00, kpc_pkg::STAT_BAD_CIPHER, 1'b1);
         end else if (!pend_valid) begin
            pend_valid = 1'b1;
            pend_row   = dval;
         end else begin
            sq_idx     = 5'((pend_row - 1) * 5 + dval - 1);
            pend_valid = 1'b0;
            pend_row   = '0;
            note_output(kpc_pkg::CHAR_UA + 8'(square_cells[sq_idx]), kpc_pkg::STAT_OK, 1'b1);
         end
      end else if (pend_valid) begin
         pend_valid = 1'b0;
         pend_row   = '0;
         note_output(8'h00, kpc_pkg::STAT_BAD_CIPHER, 1'b1);
      end else begin
         note_output(ch, kpc_pkg::STAT_OK, 1'b1);
      end
   endfunction

   // result checker
   always @(posedge clock) begin : check_outputs
      kpc_pkg::result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (queued_outputs.size() == 0) begin
            $display("%0t: unexpected result, expected none, got char %h status %0d last %b",
                     $time, rsp_tdata, rsp_tuser, rsp_tlast);
            mismatch_count++;
         end else begin
            want = queued_outputs.pop_front();
            if (rsp_tdata !== want.out_char) begin
               $display("%0t: out_char expected %h got %h", $time, want.out_char, rsp_tdata);
               mismatch_count++;
            end
            if (rsp_tuser !== want.status) begin
               $display("%0t: status expected %0d got %0d", $time, want.status, rsp_tuser);
               mismatch_count++;
            end
            if (rsp_tlast !== want.last) begin
               $display("%0t: tlast expected %b got %b", $time, want.last, rsp_tlast);
               mismatch_count++;
            end
         end
      end
   end

   // result side pacing, with an optional long hold-off
   initial begin : rsp_pacer
      int stall;
      wait (!reset);
      forever begin
         if (hold_off_cycles > 0) begin
            stall           = hold_off_cycles;
            hold_off_cycles = 0;
         end else begin
            stall = rsp_gaps ? $urandom_range(0, 16) : 0;
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   task automatic push_byte(input logic dec, input logic [7:0] ch);
      int gap;
      gap = send_gaps ? $urandom_range(0, 16) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= dec;
      req_tdata  <= ch;
      do @(posedge clock); while (!req_tready);
      predict_request(dec, ch);
   endtask

   // stop requesting and wait until every predicted result has come back
   task automatic drain_outputs();
      int spin;
      spin = 0;
      req_tvalid <= 1'b0;
      while (queued_outputs.size() != 0 && spin < 4000) begin
         @(posedge clock);
         spin++;
      end
      if (queued_outputs.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, queued_outputs.size());
         mismatch_count++;
         queued_outputs.delete();
      end
      repeat (12) @(posedge clock);
   endtask

   task automatic write_key_reg(input kpc_pkg::reg_index_type idx, input logic [59:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         kpc_pkg::REG_KEY_LENGTH: key_len  = val[4:0];
         kpc_pkg::REG_KEY_FIRST:  key_lo   = val;
         kpc_pkg::REG_KEY_SECOND: key_hi   = val;
         default:                 key_last = val[4:0];
      endcase
      rebuild_square();
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // codes: letter i at bits 5i+4..5i
   task automatic program_key(input int len, input logic [124:0] codes);
      drain_outputs();
      write_key_reg(kpc_pkg::REG_KEY_LENGTH, 60'(len));
      write_key_reg(kpc_pkg::REG_KEY_FIRST, codes[59:0]);
      write_key_reg(kpc_pkg::REG_KEY_SECOND, codes[119:60]);
      write_key_reg(kpc_pkg::REG_KEY_FINAL, 60'(codes[124:120]));
   endtask

   task automatic program_random_key(input bit make_valid);
      logic [4:0]   pool [$];
      logic [4:0]   t;
      logic [124:0] codes;
      int           len;
      int           k;
      for (int c = 0; c < 26; c++) begin
         if (c != kpc_pkg::CODE_J) begin
            pool.push_back(5'(c));
         end
      end
      for (int i = 24; i > 0; i--) begin
         k       = $urandom_range(0, i);
         t       = pool[i];
         pool[i] = pool[k];
         pool[k] = t;
      end
      len = $urandom_range(1, 25);
      for (int i = 0; i < 25; i++) begin
         codes[5*i +: 5] = (i < len) ? pool[i] : 5'($urandom);
      end
      if (!make_valid) begin
         case ($urandom_range(0, 4))
            0: len = 0;
            1: len = $urandom_range(26, 31);
            2: codes[5*$urandom_range(0, len - 1) +: 5] = kpc_pkg::CODE_J;
            3: begin
               if (len < 2) begin
                  len = 2;
               end
               codes[5*(len-1) +: 5] = codes[4:0];
            end
            default: codes[5*$urandom_range(0, len - 1) +: 5] = 5'($urandom_range(26, 31));
         endcase
      end
      program_key(len, codes);
   endtask

   task automatic probe_key();
      push_byte(1'b0, kpc_pkg::CHAR_UA + 8'($urandom_range(0, 25)));
      push_byte(1'b0, kpc_pkg::CHAR_LA + 8'd9);
      push_byte(1'b1, kpc_pkg::CHAR_ONE + 8'($urandom_range(0, 4)));
      push_byte(1'b1, kpc_pkg::CHAR_ONE + 8'($urandom_range(0, 4)));
   endtask

   task automatic test_reset_key();
      push_byte(1'b0, kpc_pkg::CHAR_UA);
      push_byte(1'b0, kpc_pkg::CHAR_FIVE);
      push_byte(1'b1, kpc_pkg::CHAR_LZ);
      push_byte(1'b1, kpc_pkg::CHAR_ONE);
      push_byte(1'b0, 8'hFF);
   endtask

   task automatic test_encrypt_edges();
      // KEYWORD
      program_key(7, 125'({5'd3, 5'd17, 5'd14, 5'd22, 5'd24, 5'd4, 5'd10}));
      push_byte(1'b0, kpc_pkg::CHAR_UA);
      push_byte(1'b0, kpc_pkg::CHAR_UZ);
      push_byte(1'b0, kpc_pkg::CHAR_LA);
      push_byte(1'b0, kpc_pkg::CHAR_LZ);
      push_byte(1'b0, kpc_pkg::CHAR_UA + 8'd9);
      push_byte(1'b0, kpc_pkg::CHAR_LA + 8'd9);
      push_byte(1'b0, 8'h20);
      push_byte(1'b0, 8'h00);
      push_byte(1'b0, 8'hFF);
      push_byte(1'b0, kpc_pkg::CHAR_ZERO);
      push_byte(1'b0, kpc_pkg::CHAR_NINE);
      push_byte(1'b0, kpc_pkg::CHAR_UA - 8'd1);
      push_byte(1'b0, kpc_pkg::CHAR_UZ + 8'd1);
   endtask

   task automatic test_decrypt_edges();
      push_byte(1'b1, kpc_pkg::CHAR_ONE);
      push_byte(1'b1, kpc_pkg::CHAR_ONE);
      push_byte(1'b1, kpc_pkg::CHAR_FIVE);
      push_byte(1'b1, kpc_pkg::CHAR_FIVE);
      // non-digit inside a pair
      push_byte(1'b1, kpc_pkg::CHAR_ONE);
      push_byte(1'b1, 8'h20);
      push_byte(1'b1, kpc_pkg::CHAR_ZERO);
      push_byte(1'b1, kpc_pkg::CHAR_FIVE + 8'd1);
      // letter while a row digit waits
      push_byte(1'b1, kpc_pkg::CHAR_ONE + 8'd1);
      push_byte(1'b1, kpc_pkg::CHAR_LA);
      // encrypt between the two digits keeps the row
      push_byte(1'b1, kpc_pkg::CHAR_ONE + 8'd2);
      push_byte(1'b0, kpc_pkg::CHAR_LA + 8'd1);
      push_byte(1'b1, kpc_pkg::CHAR_ONE + 8'd3);
      push_byte(1'b1, 8'hFF);
      push_byte(1'b1, kpc_pkg::CHAR_LA - 8'd1);
   endtask

   task automatic test_key_settings();
      logic [124:0] codes;
      int           n;
      codes = '0;
      n     = 0;
      for (int c = 25; c >= 0; c--) begin
         if (c != kpc_pkg::CODE_J) begin
            codes[5*n +: 5] = 5'(c);
            n++;
         end
      end
      program_key(25, codes);
      probe_key();
      program_key(1, 125'(5'd16));
      probe_key();
      program_key(1, '0);
      probe_key();
      program_key(0, codes);
      probe_key();
      program_key(31, codes);
      probe_key();
      program_key(26, codes);
      probe_key();
      program_key(10, {codes[124:10], codes[4:0], codes[4:0]});
      probe_key();
      codes[124:120] = kpc_pkg::CODE_J;
      program_key(25, codes);
      probe_key();
      program_key(25, '1);
      probe_key();
   endtask

   task automatic test_random_traffic(input int count);
      int         sent;
      int         next_key;
      int         n;
      logic [7:0] ch;
      sent     = 0;
      next_key = 0;
      while (sent < count) begin
         if (sent >= next_key) begin
            if ($urandom_range(0, 3) == 0) begin
               drain_outputs();
               write_key_reg(kpc_pkg::REG_KEY_LENGTH, 60'($urandom_range(0, 31)));
            end else begin
               program_random_key($urandom_range(0, 6) != 0);
            end
            send_gaps = ($urandom_range(0, 3) != 0);
            rsp_gaps  = ($urandom_range(0, 3) != 0);
            next_key  = sent + $urandom_range(40, 80);
         end
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               n = $urandom_range(1, 8);
               repeat (n) begin
                  ch = ($urandom_range(0, 1) ? kpc_pkg::CHAR_UA : kpc_pkg::CHAR_LA) +
                       8'($urandom_range(0, 25));
                  if ($urandom_range(0, 5) == 0) begin
                     ch = 8'h20;
                  end
                  push_byte(1'b0, ch);
                  sent++;
               end
            end
            4, 5, 6: begin
               n = $urandom_range(1, 4);
               repeat (n) begin
                  push_byte(1'b1, kpc_pkg::CHAR_ONE + 8'($urandom_range(0, 4)));
                  push_byte(1'b1, kpc_pkg::CHAR_ONE + 8'($urandom_range(0, 4)));
                  sent += 2;
                  if ($urandom_range(0, 3) == 0) begin
                     push_byte(1'b1, 8'h20);
                     sent++;
                  end
               end
            end
            7: begin
               push_byte(1'b1, kpc_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
               sent++;
            end
            default: begin
               push_byte(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
               sent++;
            end
         endcase
      end
   endtask

   task automatic test_backpressure();
      program_random_key(1'b1);
      send_gaps       = 1'b0;
      rsp_gaps        = 1'b1;
      hold_off_cycles = 300;
      repeat (40) begin
         push_byte(1'b0, kpc_pkg::CHAR_UA + 8'($urandom_range(0, 25)));
      end
      // sender waits for the block to empty before going on
      drain_outputs();
      send_gaps = 1'b1;
      repeat (20) begin
         push_byte(1'($urandom_range(0, 1)), kpc_pkg::CHAR_ONE + 8'($urandom_range(0, 4)));
      end
   endtask

   initial begin
      key_len  = '0;
      key_lo   = '0;
      key_hi   = '0;
      key_last = '0;
      rebuild_square();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_reset_key();
      test_encrypt_edges();
      test_decrypt_edges();
      test_key_settings();
      test_random_traffic(420);
      test_backpressure();
      drain_outputs();
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
hw/rtl/kpc_pkg.sv
hw/rtl/kpc_keysched.sv
hw/rtl/kpc_codec.sv
hw/rtl/keyed_polybius_codec_core.sv
verif/keyed_polybius_codec_core_tb.sv
